// ===== design/focl_pkg.sv =====
package focl_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [15:0] rotor_angle_raw;
    logic [11:0] adc_phase_u;
    logic [11:0] adc_phase_v;
    logic [11:0] adc_phase_w;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         duty_u;
    logic [6:0]         duty_v;
    logic [6:0]         duty_w;
    logic signed [15:0] filtered_d_current;
    logic signed [15:0] filtered_q_current;
    logic [11:0]        peak_phase_current;
  } out_item_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_D  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_Q  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_U  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_V  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_OFS = 3'd5;

  // Sequencer steps
  typedef enum logic [4:0] {
    STEP_IDLE  = 5'd0,
    STEP_ANGLE = 5'd1,
    STEP_TRIG  = 5'd2,
    STEP_S32A  = 5'd3,
    STEP_S32B  = 5'd4,
    STEP_C32   = 5'd5,
    STEP_ID0   = 5'd6,
    STEP_ID1   = 5'd7,
    STEP_ID2   = 5'd8,
    STEP_IQ0   = 5'd9,
    STEP_IQ1   = 5'd10,
    STEP_IQ2   = 5'd11,
    STEP_IDS   = 5'd12,
    STEP_IQS   = 5'd13,
    STEP_IQR   = 5'd14,
    STEP_FILT  = 5'd15,
    STEP_VD0   = 5'd16,
    STEP_VD1   = 5'd17,
    STEP_VQ0   = 5'd18,
    STEP_VQ1   = 5'd19,
    STEP_VU0   = 5'd20,
    STEP_VU1   = 5'd21,
    STEP_VV0   = 5'd22,
    STEP_VV1   = 5'd23,
    STEP_VW0   = 5'd24,
    STEP_VW1   = 5'd25,
    STEP_VWR   = 5'd26,
    STEP_MID   = 5'd27,
    STEP_FIN   = 5'd28
  } step_t;

  typedef struct packed {
    logic  load;
    step_t step;
    logic  out_load;
  } focl_cmd_t;

  // Transform constants
  localparam logic signed [21:0] K_TWO_THIRDS = 22'sd43691;
  localparam logic signed [21:0] K_SQRT3_HALF = 22'sd56756;
  localparam logic signed [21:0] K_PROP       = -22'sd1600000;
  localparam logic signed [21:0] K_INTEG      = -22'sd10000;
  localparam int FEED_SHIFT  = 24;
  localparam int INTEG_SHIFT = 10;
  localparam int DUTY_SHIFT  = 8;
  localparam logic [6:0]  DUTY_MAX = 7'd64;
  localparam logic [11:0] PEAK_MAX = 12'd2048;

  localparam logic signed [15:0] QSINE [0:64] = '{
    16'sd0, 16'sd804, 16'sd1608, 16'sd2410, 16'sd3212, 16'sd4011, 16'sd4808, 16'sd5602,
    16'sd6393, 16'sd7179, 16'sd7962, 16'sd8739, 16'sd9512, 16'sd10278, 16'sd11039,
    16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010, 16'sd14732, 16'sd15446, 16'sd16151,
    16'sd16846, 16'sd17530, 16'sd18204, 16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787,
    16'sd21403, 16'sd22005, 16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811,
    16'sd25329, 16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683, 16'sd28105,
    16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273, 16'sd30571,
    16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785, 16'sd31971, 16'sd32137,
    16'sd32285, 16'sd32412, 16'sd32521, 16'sd32609, 16'sd32678, 16'sd32728, 16'sd32757,
    16'sd32767
  };

  // Sine from the mirrored quarter wave
  function automatic logic signed [15:0] sine_at(input logic [7:0] idx);
    logic [6:0] pos;
    logic signed [15:0] v;
    pos = {1'b0, idx[5:0]};
    v = idx[6] ? QSINE[7'd64 - pos] : QSINE[pos];
    return idx[7] ? -v : v;
  endfunction

endpackage

// ===== design/focl_ctrl.sv =====
module focl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output focl_pkg::focl_cmd_t cmd
);
  import focl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, finish;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = (state_r == ST_RUN) && (step_r == STEP_FIN) &&
                     (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign cmd.load     = accept;
  assign cmd.step     = step_r;
  assign cmd.out_load = finish;

  // Sequencer: step through the schedule, hold at the end while the result slot is full
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = STEP_ANGLE;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_FIN) begin
          if (finish) begin
            state_nxt = ST_IDLE;
            step_nxt  = STEP_IDLE;
          end
        end else begin
          step_nxt = step_t'(step_r + 5'd1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = STEP_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/focl_datapath.sv =====
module focl_datapath #(
  parameter int POLE_PAIRS         = 7,
  parameter int PHASE_FILTER_SHIFT = 4,
  parameter int DQ_FILTER_SHIFT    = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  focl_pkg::focl_cmd_t               cmd,
  input  focl_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [focl_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [focl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output focl_pkg::out_item_t               out_data
);
  import focl_pkg::*;

  localparam int PP_W = $clog2(POLE_PAIRS + 1);
  localparam int PS_W = PHASE_FILTER_SHIFT + 13;
  localparam int DQ_W = DQ_FILTER_SHIFT + 16;
  localparam int ACC_W = 48;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'b00,
    MAC_LOAD = 2'b01,
    MAC_ADD  = 2'b10
  } mac_op_t;

  // Configuration registers
  logic signed [11:0] tgt_d_r, tgt_q_r;
  logic [11:0]        ofs_r [3];
  logic [14:0]        el_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_d_r  <= '0;
      tgt_q_r  <= '0;
      ofs_r[0] <= 12'd2051;
      ofs_r[1] <= 12'd2038;
      ofs_r[2] <= 12'd2044;
      el_ofs_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TGT_D:  tgt_d_r  <= cfg_wdata[11:0];
        CFG_TGT_Q:  tgt_q_r  <= cfg_wdata[11:0];
        CFG_OFS_U:  ofs_r[0] <= cfg_wdata[11:0];
        CFG_OFS_V:  ofs_r[1] <= cfg_wdata[11:0];
        CFG_OFS_W:  ofs_r[2] <= cfg_wdata[11:0];
        CFG_EL_OFS: el_ofs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Working registers
  in_item_t           item_r;
  logic [14:0]        elec_r;
  logic signed [12:0] cur_r [3];
  logic signed [PS_W-1:0] psum_r [3];
  logic [11:0]        peak_r;
  logic signed [15:0] s_r, c_r, s32_r, c32_r;
  logic signed [18:0] idp_r, iqp_r;
  logic signed [17:0] id_r, iq_r, ed_r, eq_r;
  logic signed [DQ_W-1:0] dsum_r, qsum_r;
  logic signed [15:0] fd_r, fq_r;
  logic signed [15:0] int_d_r, int_q_r;
  logic signed [15:0] vd_r, vq_r;
  logic signed [19:0] vu_r, vv_r, vw_r, mid_r;
  logic signed [ACC_W-1:0] acc_r;
  out_item_t          out_r;

  // Electrical angle
  logic [15:0]        mech;
  logic [PP_W+14:0]   mprod;
  logic [14:0]        elec;
  assign mech  = item_r.rotor_angle_raw + 16'd16384;
  assign mprod = mech[14:0] * PP_W'(POLE_PAIRS);
  assign elec  = mprod[14:0] - el_ofs_r;

  // Phase filter outputs, new sums and peak
  logic signed [12:0] cur   [3];
  logic signed [PS_W-1:0] psum_nxt [3];
  logic [11:0]        adc [3];
  logic [12:0]        cabs [3];
  logic [12:0]        pk;
  assign adc[0] = item_r.adc_phase_u;
  assign adc[1] = item_r.adc_phase_v;
  assign adc[2] = item_r.adc_phase_w;

  always_comb begin
    pk = '0;
    for (int i = 0; i < 3; i++) begin
      cur[i] = 13'(psum_r[i] >>> PHASE_FILTER_SHIFT);
      psum_nxt[i] = psum_r[i] - PS_W'(cur[i]) +
                    PS_W'($signed({1'b0, adc[i]} - {1'b0, ofs_r[i]}));
      cabs[i] = cur[i][12] ? 13'(-cur[i]) : 13'(cur[i]);
      if (cabs[i] > pk) pk = cabs[i];
    end
  end

  // Transform coefficients
  logic signed [21:0] k_s, k_c, k_s32, k_c32, k_s12, k_c12;
  assign k_s   = 22'(s_r);
  assign k_c   = 22'(c_r);
  assign k_s32 = 22'(s32_r);
  assign k_c32 = 22'(c32_r);
  assign k_s12 = 22'(s_r >>> 1);
  assign k_c12 = 22'(c_r >>> 1);

  // Shared multiplier schedule
  mac_op_t            mac_op;
  logic signed [21:0] mac_a;
  logic signed [18:0] mac_b;
  logic signed [ACC_W-1:0] mac_init;
  logic signed [40:0] prod;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    mac_op   = MAC_HOLD;
    mac_a    = '0;
    mac_b    = '0;
    mac_init = '0;
    unique case (cmd.step)
      STEP_S32A: begin mac_op = MAC_LOAD; mac_a = K_SQRT3_HALF; mac_b = 19'(s_r); end
      STEP_S32B: begin mac_op = MAC_LOAD; mac_a = K_SQRT3_HALF; mac_b = 19'(c_r); end
      STEP_ID0:  begin mac_op = MAC_LOAD; mac_a = k_c; mac_b = 19'(cur_r[0]); end
      STEP_ID1:  begin mac_op = MAC_ADD; mac_a = k_s32 - k_c12; mac_b = 19'(cur_r[1]); end
      STEP_ID2:  begin mac_op = MAC_ADD; mac_a = -k_s32 - k_c12; mac_b = 19'(cur_r[2]); end
      STEP_IQ0:  begin mac_op = MAC_LOAD; mac_a = k_s; mac_b = 19'(cur_r[0]); end
      STEP_IQ1:  begin mac_op = MAC_ADD; mac_a = -k_c32 - k_s12; mac_b = 19'(cur_r[1]); end
      STEP_IQ2:  begin mac_op = MAC_ADD; mac_a = k_c32 - k_s12; mac_b = 19'(cur_r[2]); end
      STEP_IDS:  begin mac_op = MAC_LOAD; mac_a = K_TWO_THIRDS; mac_b = idp_r; end
      STEP_IQS:  begin mac_op = MAC_LOAD; mac_a = -K_TWO_THIRDS; mac_b = iqp_r; end
      STEP_VD0: begin
        mac_op = MAC_LOAD; mac_a = K_PROP; mac_b = 19'(ed_r);
        mac_init = ACC_W'(tgt_d_r) <<< FEED_SHIFT;
      end
      STEP_VD1:  begin mac_op = MAC_ADD; mac_a = K_INTEG; mac_b = 19'(int_d_r); end
      STEP_VQ0: begin
        mac_op = MAC_LOAD; mac_a = K_PROP; mac_b = 19'(eq_r);
        mac_init = ACC_W'(tgt_q_r) <<< FEED_SHIFT;
      end
      STEP_VQ1:  begin mac_op = MAC_ADD; mac_a = K_INTEG; mac_b = 19'(int_q_r); end
      STEP_VU0:  begin mac_op = MAC_LOAD; mac_a = k_c; mac_b = 19'(vd_r); end
      STEP_VU1:  begin mac_op = MAC_ADD; mac_a = -k_s; mac_b = 19'(vq_r); end
      STEP_VV0:  begin mac_op = MAC_LOAD; mac_a = k_s32 - k_c12; mac_b = 19'(vd_r); end
      STEP_VV1:  begin mac_op = MAC_ADD; mac_a = k_c32 + k_s12; mac_b = 19'(vq_r); end
      STEP_VW0:  begin mac_op = MAC_LOAD; mac_a = -(k_s32 + k_c12); mac_b = 19'(vd_r); end
      STEP_VW1:  begin mac_op = MAC_ADD; mac_a = -(k_c32 - k_s12); mac_b = 19'(vq_r); end
      default: ;
    endcase
  end

  assign prod = mac_a * mac_b;

  always_comb begin
    unique case (mac_op)
      MAC_LOAD: acc_nxt = mac_init + ACC_W'(prod);
      MAC_ADD:  acc_nxt = acc_r + ACC_W'(prod);
      default:  acc_nxt = acc_r;
    endcase
  end

  // Accumulator views
  logic signed [ACC_W-1:0] acc_sh16, acc_sh15;
  logic signed [15:0]      v_sat;
  assign acc_sh16 = acc_r >>> 16;
  assign acc_sh15 = acc_r >>> 15;
  always_comb begin
    if (acc_sh16 > ACC_W'(32767)) v_sat = 16'sd32767;
    else if (acc_sh16 < -ACC_W'(32768)) v_sat = -16'sd32768;
    else v_sat = acc_sh16[15:0];
  end

  // d/q filters, errors and saturated integrators
  logic signed [15:0] fd, fq;
  logic signed [17:0] ed, eq;
  logic signed [17:0] int_d_sum, int_q_sum;
  logic signed [15:0] int_d_nxt, int_q_nxt;
  assign fd = 16'(dsum_r >>> DQ_FILTER_SHIFT);
  assign fq = 16'(qsum_r >>> DQ_FILTER_SHIFT);
  assign ed = 18'(tgt_d_r) - id_r;
  assign eq = 18'(tgt_q_r) - iq_r;
  assign int_d_sum = 18'(int_d_r) + (ed >>> INTEG_SHIFT);
  assign int_q_sum = 18'(int_q_r) + (eq >>> INTEG_SHIFT);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sd32767;
    if (v < -18'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  assign int_d_nxt = sat16(int_d_sum);
  assign int_q_nxt = sat16(int_q_sum);

  // Centring and duties
  logic signed [19:0] lo, hi;
  logic signed [20:0] mid_sum;
  always_comb begin
    lo = (vu_r < vv_r) ? vu_r : vv_r;
    lo = (vw_r < lo) ? vw_r : lo;
    hi = (vu_r > vv_r) ? vu_r : vv_r;
    hi = (vw_r > hi) ? vw_r : hi;
    mid_sum = 21'(lo) + 21'(hi);
  end

  function automatic logic [6:0] duty_of(input logic signed [19:0] v,
                                         input logic signed [19:0] m);
    logic signed [20:0] d;
    d = ((21'(v) - 21'(m)) >>> DUTY_SHIFT) + 21'sd32;
    if (d < 21'sd0) return 7'd0;
    if (d > 21'(DUTY_MAX)) return DUTY_MAX;
    return d[6:0];
  endfunction

  // Register writes per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) psum_r[i] <= '0;
      dsum_r  <= '0;
      qsum_r  <= '0;
      int_d_r <= '0;
      int_q_r <= '0;
    end else begin
      unique case (cmd.step)
        STEP_ANGLE: for (int i = 0; i < 3; i++) psum_r[i] <= psum_nxt[i];
        STEP_FILT: begin
          dsum_r  <= dsum_r - DQ_W'(fd) + DQ_W'(id_r);
          qsum_r  <= qsum_r - DQ_W'(fq) + DQ_W'(iq_r);
          int_d_r <= int_d_nxt;
          int_q_r <= int_q_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    acc_r <= acc_nxt;
    unique case (cmd.step)
      STEP_ANGLE: begin
        elec_r <= elec;
        for (int i = 0; i < 3; i++) cur_r[i] <= cur[i];
        peak_r <= (pk > 13'(PEAK_MAX)) ? PEAK_MAX : pk[11:0];
      end
      STEP_TRIG: begin
        s_r <= sine_at(elec_r[14:7]);
        c_r <= sine_at(8'd64 - elec_r[14:7]);
      end
      STEP_S32B: s32_r <= acc_sh16[15:0];
      STEP_C32:  c32_r <= acc_sh16[15:0];
      STEP_IQ0:  idp_r <= acc_sh16[18:0];
      STEP_IDS:  iqp_r <= acc_sh16[18:0];
      STEP_IQS:  id_r  <= acc_sh15[17:0];
      STEP_IQR:  iq_r  <= acc_sh15[17:0];
      STEP_FILT: begin
        fd_r <= fd;
        fq_r <= fq;
        ed_r <= ed;
        eq_r <= eq;
      end
      STEP_VQ0: vd_r <= v_sat;
      STEP_VU0: vq_r <= v_sat;
      STEP_VV0: vu_r <= acc_sh15[19:0];
      STEP_VW0: vv_r <= acc_sh15[19:0];
      STEP_VWR: vw_r <= acc_sh15[19:0];
      STEP_MID: mid_r <= 20'(mid_sum >>> 1);
      STEP_FIN: begin
        if (cmd.out_load) begin
          out_r.duty_u             <= duty_of(vu_r, mid_r);
          out_r.duty_v             <= duty_of(vv_r, mid_r);
          out_r.duty_w             <= duty_of(vw_r, mid_r);
          out_r.filtered_d_current <= fd_r;
          out_r.filtered_q_current <= fq_r;
          out_r.peak_phase_current <= peak_r;
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// ===== design/foc_current_loop_core.sv =====
// Field-oriented current loop, one request per control period.
// Input channel (in_valid/in_ready/in_data): rotor angle word and three
// phase ADC samples. Result channel (out_valid/out_ready/out_data): three
// PWM duties 0..64, filtered d/q currents and peak phase current.
// Configuration: cfg_we/cfg_addr/cfg_wdata write targets, phase offsets and
// the electrical offset; write only while no request is in flight.
// The sequencer steps the single shared 22x19 multiplier through 20 products,
// plus angle, table, filter and centring steps; a new request is accepted
// only after the previous one has finished all of its steps.
// in_ready is high whenever the sequencer is idle, even while a result
// waits; if the previous result is still untaken when the next one is done,
// the sequencer holds on its last step until out_ready frees the slot.
// Reset (rst_n low, synchronous) clears the filter sums and integrators,
// restores the default offsets and drops out_valid.
module foc_current_loop_core #(
  parameter int POLE_PAIRS         = 7,
  parameter int PHASE_FILTER_SHIFT = 4,
  parameter int DQ_FILTER_SHIFT    = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  focl_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output focl_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [focl_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [focl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import focl_pkg::*;

  focl_cmd_t cmd;

  focl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  focl_datapath #(
    .POLE_PAIRS         (POLE_PAIRS),
    .PHASE_FILTER_SHIFT (PHASE_FILTER_SHIFT),
    .DQ_FILTER_SHIFT    (DQ_FILTER_SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// ===== test/foc_current_loop_core_tb.sv =====
`timescale 1ns / 1ps

module foc_current_loop_core_tb;
  import focl_pkg::*;

  // Indexes past the last register, written to check that they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  foc_current_loop_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Clock, 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  in_item_t  pending_reqs[$];
  out_item_t expected_duties[$];
  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_send;
  logic [15:0] last_angle;

  // Loop model: configuration and state
  int  tgt_d, tgt_q;
  int  ofs_u, ofs_v, ofs_w;
  int  el_ofs;
  int  phase_sum[3];
  int  dq_sum[2];
  int  dq_integ[2];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint table_sine(int idx);
    int quad;
    int pos;
    longint v;
    quad = (idx & 255) / 64;
    pos = (idx & 255) % 64;
    v = (quad & 1) ? QSINE[64 - pos] : QSINE[pos];
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint to_duty(longint v, longint mid);
    return clamp(((v - mid) >>> 8) + 32, 0, 64);
  endfunction

  // Runs one control period and returns the result it should produce
  function automatic out_item_t control_period(in_item_t req);
    out_item_t r;
    int unsigned mech, elec;
    int lut;
    longint s, c, s32, c32, s12, c12;
    longint cur[3];
    longint adc[3], ofs[3];
    longint peak, a, id, iq, fd, fq, ed, eq, vd, vq, vu, vv, vw, lo, hi, mid;
    adc[0] = req.adc_phase_u;
    adc[1] = req.adc_phase_v;
    adc[2] = req.adc_phase_w;
    ofs[0] = ofs_u;
    ofs[1] = ofs_v;
    ofs[2] = ofs_w;
    mech = (int'(req.rotor_angle_raw) + 16384) & 32'hFFFF;
    elec = (mech * 7 - el_ofs) & 32'h7FFF;
    lut = elec >> 7;
    s = table_sine(lut);
    c = table_sine(64 + 256 - lut);
    s32 = (longint'(56756) * s) >>> 16;
    c32 = (longint'(56756) * c) >>> 16;
    s12 = (longint'(32768) * s) >>> 16;
    c12 = (longint'(32768) * c) >>> 16;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      cur[i] = longint'(phase_sum[i]) >>> 4;
      phase_sum[i] = int'(longint'(phase_sum[i]) - cur[i] + (adc[i] - ofs[i]));
      a = cur[i] < 0 ? -cur[i] : cur[i];
      if (a > peak) peak = a;
    end
    peak = clamp(peak, 0, 2048);
    id = (c * cur[0] + (s32 - c12) * cur[1] + (-s32 - c12) * cur[2]) >>> 16;
    iq = (s * cur[0] + (-c32 - s12) * cur[1] + (c32 - s12) * cur[2]) >>> 16;
    id = (id * 43691) >>> 15;
    iq = (iq * -43691) >>> 15;
    fd = longint'(dq_sum[0]) >>> 8;
    dq_sum[0] = int'(longint'(dq_sum[0]) - fd + id);
    fq = longint'(dq_sum[1]) >>> 8;
    dq_sum[1] = int'(longint'(dq_sum[1]) - fq + iq);
    ed = tgt_d - id;
    eq = tgt_q - iq;
    dq_integ[0] = int'(clamp(dq_integ[0] + (ed >>> 10), -32768, 32767));
    dq_integ[1] = int'(clamp(dq_integ[1] + (eq >>> 10), -32768, 32767));
    vd = clamp((longint'(-1600000) * ed + longint'(-10000) * dq_integ[0]
                + (longint'(tgt_d) <<< 24)) >>> 16, -32768, 32767);
    vq = clamp((longint'(-1600000) * eq + longint'(-10000) * dq_integ[1]
                + (longint'(tgt_q) <<< 24)) >>> 16, -32768, 32767);
    vu = (c * vd - s * vq) >>> 15;
    vv = ((s32 - c12) * vd + (c32 + s12) * vq) >>> 15;
    vw = (-(s32 + c12) * vd - (c32 - s12) * vq) >>> 15;
    lo = vu < vv ? vu : vv;
    lo = vw < lo ? vw : lo;
    hi = vu > vv ? vu : vv;
    hi = vw > hi ? vw : hi;
    mid = (lo + hi) >>> 1;
    r.duty_u = 7'(to_duty(vu, mid));
    r.duty_v = 7'(to_duty(vv, mid));
    r.duty_w = 7'(to_duty(vw, mid));
    r.filtered_d_current = fd[15:0];
    r.filtered_q_current = fq[15:0];
    r.peak_phase_current = peak[11:0];
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_duties.push_back(control_period(in_data));
      if (pending_reqs.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = expected_duties.pop_front();
          if (out_data.duty_u !== exp_r.duty_u) begin
            $error("duty_u exp %0d got %0d", exp_r.duty_u, out_data.duty_u);
            errors++;
          end
          if (out_data.duty_v !== exp_r.duty_v) begin
            $error("duty_v exp %0d got %0d", exp_r.duty_v, out_data.duty_v);
            errors++;
          end
          if (out_data.duty_w !== exp_r.duty_w) begin
            $error("duty_w exp %0d got %0d", exp_r.duty_w, out_data.duty_w);
            errors++;
          end
          if (out_data.filtered_d_current !== exp_r.filtered_d_current) begin
            $error("filtered_d_current exp %0d got %0d",
                   exp_r.filtered_d_current, out_data.filtered_d_current);
            errors++;
          end
          if (out_data.filtered_q_current !== exp_r.filtered_q_current) begin
            $error("filtered_q_current exp %0d got %0d",
                   exp_r.filtered_q_current, out_data.filtered_q_current);
            errors++;
          end
          if (out_data.peak_phase_current !== exp_r.peak_phase_current) begin
            $error("peak_phase_current exp %0d got %0d",
                   exp_r.peak_phase_current, out_data.peak_phase_current);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Register write; the model takes the value when the write is driven, before the core registers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TGT_D:  tgt_d = int'(signed'(val[11:0]));
      CFG_TGT_Q:  tgt_q = int'(signed'(val[11:0]));
      CFG_OFS_U:  ofs_u = int'(val[11:0]);
      CFG_OFS_V:  ofs_v = int'(val[11:0]);
      CFG_OFS_W:  ofs_w = int'(val[11:0]);
      CFG_EL_OFS: el_ofs = int'(val[14:0]);
      default: ;
    endcase
  endtask

  // Whole register set, junk in the bits above each 12-bit field, then a spare index
  task automatic set_loop(int td, int tq, int ou, int ov, int ow, int eo);
    write_reg(CFG_TGT_D,  {3'($urandom), 12'(td)});
    write_reg(CFG_TGT_Q,  {3'($urandom), 12'(tq)});
    write_reg(CFG_OFS_U,  {3'($urandom), 12'(ou)});
    write_reg(CFG_OFS_V,  {3'($urandom), 12'(ov)});
    write_reg(CFG_OFS_W,  {3'($urandom), 12'(ow)});
    write_reg(CFG_EL_OFS, 15'(eo));
    write_reg(($urandom_range(1) != 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
              15'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_duties.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] near_ofs(int ofs);
    return 12'(clamp(ofs + int'($urandom_range(600)) - 300, 0, 4095));
  endfunction

  // Mostly smooth rotation with samples near the offsets, some raw noise
  function automatic in_item_t make_req();
    in_item_t q;
    if ($urandom_range(99) < 70) begin
      last_angle = last_angle + 16'($urandom_range(600));
      q.rotor_angle_raw = last_angle;
      q.adc_phase_u = near_ofs(ofs_u);
      q.adc_phase_v = near_ofs(ofs_v);
      q.adc_phase_w = near_ofs(ofs_w);
    end else begin
      q = in_item_t'($urandom) ^ (in_item_t'($urandom) << 20);
    end
    return q;
  endfunction

  task automatic push_req(logic [15:0] ang, logic [11:0] u, logic [11:0] v,
                          logic [11:0] w);
    pending_reqs.push_back({ang, u, v, w});
  endtask

  task automatic random_phase(int n, int send_pct, int recv_pct, bit pause);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) pending_reqs.push_back(make_req());
    if (pause) begin
      // sender holds off until every result is back
      while (pending_reqs.size() > n / 2) @(posedge clk);
      hold_send = 1'b1;
      while (in_valid || expected_duties.size() > 0) @(posedge clk);
      repeat (5) @(posedge clk);
      hold_send = 1'b0;
    end
    drain();
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    hold_send = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    last_angle = '0;
    tgt_d = 0; tgt_q = 0;
    ofs_u = 2051; ofs_v = 2038; ofs_w = 2044;
    el_ofs = 0;
    for (int i = 0; i < 3; i++) phase_sum[i] = 0;
    for (int i = 0; i < 2; i++) begin
      dq_sum[i] = 0;
      dq_integ[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, field extremes
    push_req(16'h0000, 12'd2051, 12'd2038, 12'd2044);
    push_req(16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    push_req(16'h4000, 12'h000, 12'h000, 12'h000);
    push_req(16'hC000, 12'hFFF, 12'h000, 12'hAAA);
    push_req(16'h8000, 12'h555, 12'hFFF, 12'h000);
    drain();
    // Peak saturation, positive then negative, at extreme targets
    set_loop(2047, -2048, 0, 0, 0, 32767);
    repeat (14) push_req(16'($urandom), 12'hFFF, 12'hFFF, 12'hFFF);
    drain();
    set_loop(-2048, 2047, 4095, 4095, 4095, 0);
    repeat (30) push_req(16'($urandom), 12'h000, 12'h000, 12'h000);
    drain();

    // Random phases over several settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_loop(0, 0, 2051, 2038, 2044, 0);
        1: set_loop($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                    $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(32767));
        2: set_loop(2047, 2047, 4095, 0, 4095, 32767);
        default: set_loop($urandom_range(400) - 200, $urandom_range(2000) - 1000,
                          1900 + $urandom_range(300), 1900 + $urandom_range(300),
                          1900 + $urandom_range(300), $urandom_range(32767));
      endcase
      case (ph % 4)
        0: random_phase(200, 0, 0, ph == 0);
        1: random_phase(200, 72, 0, 1'b0);
        2: random_phase(200, 0, 72, 1'b0);
        default: random_phase(200, 13, 13, 1'b0);
      endcase
    end

    if (errors == 0) begin
      $display("foc_current_loop_core_tb passed");
    end else begin
      $display("foc_current_loop_core_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("foc_current_loop_core_tb failed");
    $finish;
  end

endmodule
